>>> src/pqs_pkg.sv
// ----------------------------------------------------------------------------
// pqs_pkg
// Operation and status codes and default sizes for the sorted priority queue.
// ----------------------------------------------------------------------------
package pqs_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW = 8;
  localparam int unsigned OccW = 5;

  typedef enum logic [1:0] {
    KIND_ENQ        = 2'd0,
    KIND_DEQ        = 2'd1,
    KIND_PEEK_FRONT = 2'd2,
    KIND_PEEK_BACK  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  localparam logic [ValueW-1:0] EmptyValue = '1;

endpackage

>>> src/priority_queue_sorted_unit.sv
// ----------------------------------------------------------------------------
// priority_queue_sorted_unit
// Bounded priority queue of value/priority pairs kept sorted in one memory.
// ----------------------------------------------------------------------------
// channel | ports                                          | dir
// in      | in_valid in_ready in_kind in_item_value in_item_priority | in
// out     | out_valid out_ready out_status out_result_value out_occupancy | out
//
// A peek passes through S_FRONT and then S_DONE before out_valid rises; an
// empty or refused operation goes straight to S_DONE. An enqueue or dequeue
// runs a read-modify-write loop that moves one entry per read/write state
// pair through the one memory, from the front of the queue towards its back.
// Reset (rst_n low, synchronous) empties the queue; the memory is not cleared.
// A stalled result holds in the output register; the next transfer is taken
// the cycle after it leaves.
module priority_queue_sorted_unit #(
  parameter int unsigned CAPACITY = pqs_pkg::DefCapacity
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_kind,
  input  logic signed [pqs_pkg::ValueW-1:0] in_item_value,
  input  logic [pqs_pkg::PrioW-1:0] in_item_priority,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic signed [pqs_pkg::ValueW-1:0] out_result_value,
  output logic [pqs_pkg::OccW-1:0]  out_occupancy
);
  import pqs_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = ValueW + PrioW;

  typedef enum logic [2:0] {
    S_IDLE, S_FRONT, S_ENQ_RD, S_ENQ_WR, S_DEQ_RD, S_DEQ_WR, S_DONE
  } state_t;

  state_t state_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic [1:0]    kind_r;
  logic [ValueW-1:0] val_r;
  logic [PrioW-1:0]  prio_r;
  logic [EW-1:0] carry_r;
  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rdata_r;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_ra, mem_wa;
  logic [EW-1:0] mem_wd;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [ValueW-1:0] out_val_r;
  logic [OccW-1:0]   out_occ_r;
  logic              placed_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_r <= mem[mem_ra];
  end

  logic [PrioW-1:0] rd_prio;
  assign rd_prio = rdata_r[PrioW-1:0];

  // Control: memory read enable and address, and write.
  always_comb begin
    mem_re = 1'b0;
    mem_ra = idx_r[AW-1:0];
    mem_we = 1'b0;
    mem_wa = idx_r[AW-1:0];
    mem_wd = carry_r;
    unique case (state_r)
      S_FRONT, S_ENQ_RD, S_DEQ_RD: mem_re = 1'b1;
      S_ENQ_WR: begin
        mem_we = 1'b1;
        mem_wd = placed_r ? carry_r : rdata_r;
        if (!placed_r && rd_prio < prio_r) mem_wd = {val_r, prio_r};
        if (idx_r == count_r) mem_wd = placed_r ? carry_r : {val_r, prio_r};
      end
      S_DEQ_WR: begin
        mem_we = 1'b1;
        mem_wa = AW'(idx_r - CW'(1));
        mem_wd = rdata_r;
      end
      default: ;
    endcase
  end

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      placed_r    <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          kind_r   <= in_kind;
          val_r    <= in_item_value;
          prio_r   <= in_item_priority;
          placed_r <= 1'b0;
          if (in_kind == KIND_ENQ) begin
            if (count_r == CW'(CAPACITY)) begin
              out_status_r <= ST_FULL;
              out_val_r    <= '0;
              state_r      <= S_DONE;
            end else begin
              idx_r   <= '0;
              state_r <= S_ENQ_RD;
            end
          end else if (count_r == '0) begin
            out_status_r <= ST_EMPTY;
            out_val_r    <= EmptyValue;
            state_r      <= S_DONE;
          end else begin
            out_status_r <= ST_OK;
            idx_r <= (in_kind == KIND_PEEK_BACK) ? CW'(count_r - CW'(1)) : '0;
            state_r <= S_FRONT;
          end
        end
        S_FRONT: begin
          state_r <= (kind_r == KIND_DEQ) ? S_DEQ_RD : S_DONE;
          idx_r   <= CW'(idx_r + CW'(1));
          if (kind_r != KIND_DEQ) idx_r <= idx_r;
        end
        S_DEQ_RD: begin
          if (idx_r == CW'(1)) out_val_r <= rdata_r[EW-1:PrioW];
          if (idx_r == count_r) begin
            count_r <= CW'(count_r - CW'(1));
            state_r <= S_DONE;
          end else begin
            state_r <= S_DEQ_WR;
          end
        end
        S_DEQ_WR: begin
          idx_r   <= CW'(idx_r + CW'(1));
          state_r <= S_DEQ_RD;
        end
        S_ENQ_RD: state_r <= S_ENQ_WR;
        S_ENQ_WR: begin
          if (idx_r == count_r) begin
            count_r      <= CW'(count_r + CW'(1));
            out_status_r <= ST_OK;
            out_val_r    <= '0;
            state_r      <= S_DONE;
          end else begin
            if (placed_r || rd_prio < prio_r) begin
              placed_r <= 1'b1;
              carry_r  <= rdata_r;
            end
            idx_r   <= CW'(idx_r + CW'(1));
            state_r <= S_ENQ_RD;
          end
        end
        S_DONE: begin
          if (kind_r != KIND_DEQ && out_status_r == ST_OK && kind_r != KIND_ENQ)
            out_val_r <= rdata_r[EW-1:PrioW];
          out_occ_r   <= OccW'(count_r);
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_val_r;
  assign out_occupancy    = out_occ_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY)) else $error("count overflow");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_val_r))
    else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("accept while busy");

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted priority queue. A predictor holds its own
// sorted copy of the queue; each result transfer is compared against the
// oldest expected result. Directed edge cases and a long result stall come
// first, then random traffic with random gaps on both sides but for its last 150 operations.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pqs_pkg::*;

  localparam int unsigned Depth = DefCapacity;
  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    status_t           status;
    logic [ValueW-1:0] value;
    logic [OccW-1:0]   occ;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_kind = KIND_PEEK_FRONT;
  logic signed [ValueW-1:0] in_item_value = '0;
  logic [PrioW-1:0] in_item_priority = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic signed [ValueW-1:0] out_result_value;
  logic [OccW-1:0] out_occupancy;

  logic [ValueW-1:0] q_val[$];
  logic [PrioW-1:0] q_pri[$];
  outcome_t pending[$];
  int errors = 0;
  int idle_cycles = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  bit long_hold = 1'b0;
  int hold_off = 0;

  priority_queue_sorted_unit #(.CAPACITY(Depth)) u_dut (.*);

  always #10 clk = ~clk;

  function automatic outcome_t queue_apply(kind_t k, logic [ValueW-1:0] v,
                                           logic [PrioW-1:0] p);
    outcome_t r;
    int pos;
    r.status = ST_OK;
    r.value = '0;
    if (k == KIND_ENQ) begin
      if (q_val.size() >= Depth) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < q_pri.size() && q_pri[pos] >= p) pos++;
        q_val.insert(pos, v);
        q_pri.insert(pos, p);
      end
    end else if (q_val.size() == 0) begin
      r.status = ST_EMPTY;
      r.value = EmptyValue;
    end else if (k == KIND_DEQ) begin
      r.value = q_val.pop_front();
      void'(q_pri.pop_front());
    end else if (k == KIND_PEEK_FRONT) begin
      r.value = q_val[0];
    end else begin
      r.value = q_val[q_val.size()-1];
    end
    r.occ = OccW'(q_val.size());
    return r;
  endfunction

  task automatic send_op(kind_t k, logic [ValueW-1:0] v, logic [PrioW-1:0] p);
    int gap;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_item_value <= v;
    in_item_priority <= p;
    do @(posedge clk); while (!in_ready);
    pending.push_back(queue_apply(k, v, p));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    int burst;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (long_hold) begin
      long_hold = 1'b0;
      hold_off <= 399;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
      burst = $urandom_range(1, 13);
      hold_off <= burst - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $display("%0t unexpected result: status %0d value %0h occ %0d", $time,
                 out_status, out_result_value, out_occupancy);
        errors++;
      end else begin
        e = pending.pop_front();
        if (out_status != e.status) begin
          $display("%0t status: expected %0d actual %0d", $time, e.status, out_status);
          errors++;
        end
        if (out_result_value != e.value) begin
          $display("%0t value: expected %0h actual %0h", $time, e.value,
                   out_result_value);
          errors++;
        end
        if (out_occupancy != e.occ) begin
          $display("%0t occupancy: expected %0d actual %0d", $time, e.occ,
                   out_occupancy);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_empty_queue();
    send_op(KIND_DEQ, 32'h1234, 8'h00);
    send_op(KIND_PEEK_FRONT, '0, 8'hff);
    send_op(KIND_PEEK_BACK, '1, 8'h55);
  endtask

  task automatic test_fill_and_drain();
    send_op(KIND_ENQ, 32'h8000_0000, 8'h00);
    send_op(KIND_ENQ, 32'h7fff_ffff, 8'hff);
    send_op(KIND_ENQ, 32'hffff_ffff, 8'h80);
    send_op(KIND_ENQ, 32'h0000_0001, 8'h80);
    send_op(KIND_PEEK_FRONT, '0, '0);
    send_op(KIND_PEEK_BACK, '0, '0);
    for (int i = 0; i < 13; i++) send_op(KIND_ENQ, 32'h100 + i, 8'(i & 3));
    send_op(KIND_PEEK_BACK, '0, '0);
    for (int i = 0; i < 4; i++) send_op(KIND_DEQ, '0, '0);
  endtask

  task automatic test_long_stall();
    long_hold = 1'b1;
    for (int i = 0; i < 40; i++) send_op(kind_t'($urandom_range(0, 3)), $urandom,
                                         8'($urandom_range(0, 3)));
    wait_drain();
  endtask

  task automatic test_random(int count);
    kind_t k;
    for (int i = 0; i < count; i++) begin
      if (i == count - 150) begin
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: k = KIND_ENQ;
        4, 5, 6: k = KIND_DEQ;
        7: k = KIND_PEEK_FRONT;
        default: k = KIND_PEEK_BACK;
      endcase
      send_op(k, $urandom, 8'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                                            : $urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_fill_and_drain();
    test_long_stall();
    test_random(1080);
    wait_drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
